### sv/ted_pkg.sv
// Package for the text encoding detector: counter width, encoding codes,
// the scanner status struct and GBK byte-class helpers.
// No dependencies.
package ted_pkg;

  // Width of the saturating non-ASCII and pair counters
  localparam int unsigned CountBits = 32;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Encoding classes reported at the end of a stream
  typedef enum logic [2:0] {
    EncUtf8    = 3'd0,
    EncUtf8Bom = 3'd1,
    EncUtf16Le = 3'd2,
    EncUtf16Be = 3'd3,
    EncGbk     = 3'd4,
    EncLatin1  = 3'd5
  } encoding_e;

  // Scanner state after the current byte, handed to the classifier
  typedef struct packed {
    logic [1:0]           head_count;
    logic [15:0]          head_bytes;
    logic                 bom8_match;
    logic [1:0]           utf8_pending;
    logic                 utf8_bad;
    logic [CountBits-1:0] nonascii_total;
    logic [CountBits-1:0] pair_total;
  } ted_status_t;

  // GBK lead byte: 0x81..0xFE
  function automatic logic gbk_lead(input logic [7:0] b);
    gbk_lead = (b >= 8'h81) && (b <= 8'hFE);
  endfunction

  // GBK trail byte: 0x40..0x7E or 0x80..0xFE
  function automatic logic gbk_trail(input logic [7:0] b);
    gbk_trail = ((b >= 8'h40) && (b <= 8'h7E)) || ((b >= 8'h80) && (b <= 8'hFE));
  endfunction

  // Saturating increment of a counter
  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
    sat_inc = (v == CountMax) ? v : v + CountBits'(1);
  endfunction

endpackage

### sv/ted_scan.sv
// Per-byte scanner of the text encoding detector: BOM head capture,
// UTF-8 lead/continuation tracker and GBK pair scanner.
// Depends on ted_pkg.
module ted_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 has_byte_i,
  input  logic                 last_i,
  input  logic [7:0]           data_byte_i,
  output ted_pkg::ted_status_t status_o
);

  logic [1:0]                    head_count_q, head_count_d;
  logic [15:0]                   head_bytes_q, head_bytes_d;
  logic                          bom8_match_q, bom8_match_d;
  logic [1:0]                    utf8_pending_q, utf8_pending_d;
  logic                          utf8_bad_q, utf8_bad_d;
  logic                          gbk_wait_q, gbk_wait_d;
  logic [ted_pkg::CountBits-1:0] nonascii_q, nonascii_d;
  logic [ted_pkg::CountBits-1:0] pairs_q, pairs_d;
  logic                          take;

  assign take = accept_i && has_byte_i;

  // Update all trackers with the incoming byte
  always_comb begin
    head_count_d   = head_count_q;
    head_bytes_d   = head_bytes_q;
    bom8_match_d   = bom8_match_q;
    utf8_pending_d = utf8_pending_q;
    utf8_bad_d     = utf8_bad_q;
    gbk_wait_d     = gbk_wait_q;
    nonascii_d     = nonascii_q;
    pairs_d        = pairs_q;
    if (take) begin
      // capture the head for BOM matching
      unique case (head_count_q)
        2'd0: begin
          head_bytes_d = {data_byte_i, 8'h00};
          head_count_d = 2'd1;
        end
        2'd1: begin
          head_bytes_d = {head_bytes_q[15:8], data_byte_i};
          head_count_d = 2'd2;
        end
        2'd2: begin
          bom8_match_d = (head_bytes_q == 16'hEFBB) && (data_byte_i == 8'hBF);
          head_count_d = 2'd3;
        end
        default: begin
          head_count_d = head_count_q;
        end
      endcase

      // UTF-8 lead and continuation tracking
      if (!utf8_bad_q) begin
        if (utf8_pending_q != 2'd0) begin
          if (data_byte_i[7:6] == 2'b10) begin
            utf8_pending_d = utf8_pending_q - 2'd1;
          end else begin
            utf8_bad_d = 1'b1;
          end
        end else if (data_byte_i[7]) begin
          priority if (!data_byte_i[6]) begin
            utf8_bad_d = 1'b1;
          end else if (!data_byte_i[5]) begin
            utf8_pending_d = 2'd1;
          end else if (!data_byte_i[4]) begin
            utf8_pending_d = 2'd2;
          end else begin
            utf8_pending_d = 2'd3;
          end
        end
      end

      // GBK pair scanning with one byte of lookahead
      if (gbk_wait_q && ted_pkg::gbk_trail(data_byte_i)) begin
        pairs_d    = ted_pkg::sat_inc(pairs_q);
        gbk_wait_d = 1'b0;
      end else begin
        gbk_wait_d = 1'b0;
        if (data_byte_i[7]) begin
          nonascii_d = ted_pkg::sat_inc(nonascii_q);
          gbk_wait_d = ted_pkg::gbk_lead(data_byte_i);
        end
      end
    end
  end

  // Hand the post-byte state to the classifier
  always_comb begin
    status_o.head_count     = head_count_d;
    status_o.head_bytes     = head_bytes_d;
    status_o.bom8_match     = bom8_match_d;
    status_o.utf8_pending   = utf8_pending_d;
    status_o.utf8_bad       = utf8_bad_d;
    status_o.nonascii_total = nonascii_d;
    status_o.pair_total     = pairs_d;
  end

  // Hold state between bytes; clear at the end of each stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_count_q   <= 2'd0;
      head_bytes_q   <= 16'h0000;
      bom8_match_q   <= 1'b0;
      utf8_pending_q <= 2'd0;
      utf8_bad_q     <= 1'b0;
      gbk_wait_q     <= 1'b0;
      nonascii_q     <= '0;
      pairs_q        <= '0;
    end else if (accept_i && last_i) begin
      head_count_q   <= 2'd0;
      head_bytes_q   <= 16'h0000;
      bom8_match_q   <= 1'b0;
      utf8_pending_q <= 2'd0;
      utf8_bad_q     <= 1'b0;
      gbk_wait_q     <= 1'b0;
      nonascii_q     <= '0;
      pairs_q        <= '0;
    end else begin
      head_count_q   <= head_count_d;
      head_bytes_q   <= head_bytes_d;
      bom8_match_q   <= bom8_match_d;
      utf8_pending_q <= utf8_pending_d;
      utf8_bad_q     <= utf8_bad_d;
      gbk_wait_q     <= gbk_wait_d;
      nonascii_q     <= nonascii_d;
      pairs_q        <= pairs_d;
    end
  end

endmodule

### sv/text_encoding_detector_core.sv
// Top level of the text encoding detector: byte scanner, end-of-stream
// classifier and result register.
// Depends on ted_pkg and ted_scan.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | in_valid_i / in_ready_o | data_byte_i[7:0], has_byte_i, last_i
//  result   | out_valid_o/out_ready_i | encoding_o[2:0]
//
// One transaction is taken every cycle unless stalled; its byte updates the
// scanner state in that same cycle. A transaction with last set yields one
// result in the result register on the next cycle and clears the scanner
// for a new stream. Reset clears the scanner and empties the result register.
// The input stalls only while a result waits and the result side is not ready.
module text_encoding_detector_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] encoding_o
);

  logic                  accept;
  ted_pkg::ted_status_t  status;
  ted_pkg::encoding_e    enc_d;
  ted_pkg::encoding_e    enc_q;
  logic                  out_valid_q;
  logic [ted_pkg::CountBits+1:0] pairs_x4;
  logic [ted_pkg::CountBits+1:0] nonascii_x;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ted_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .data_byte_i (data_byte_i),
    .status_o    (status)
  );

  assign pairs_x4   = {status.pair_total, 2'b00};
  assign nonascii_x = {2'b00, status.nonascii_total};

  // Classify the stream from the state after its final byte
  always_comb begin
    priority if (status.head_count == 2'd3 && status.bom8_match) begin
      enc_d = ted_pkg::EncUtf8Bom;
    end else if (status.head_count >= 2'd2 && status.head_bytes == 16'hFFFE) begin
      enc_d = ted_pkg::EncUtf16Le;
    end else if (status.head_count >= 2'd2 && status.head_bytes == 16'hFEFF) begin
      enc_d = ted_pkg::EncUtf16Be;
    end else if (status.head_count == 2'd0) begin
      enc_d = ted_pkg::EncUtf8;
    end else if (!status.utf8_bad && status.utf8_pending == 2'd0) begin
      enc_d = ted_pkg::EncUtf8;
    end else if (status.nonascii_total != '0 && pairs_x4 > nonascii_x) begin
      enc_d = ted_pkg::EncGbk;
    end else begin
      enc_d = ted_pkg::EncLatin1;
    end
  end

  // Result valid: set on a last transaction, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      enc_q <= enc_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign encoding_o  = 3'(enc_q);

endmodule
